### rtl/oahs_pkg.sv
// shared types, constants and codes for the open-address hash set
package oahs_pkg;

   localparam int SLOT_DEPTH = 1024;
   localparam int ADDR_W     = $clog2(SLOT_DEPTH);
   localparam int KEY_W      = 31;
   localparam int SIZE_W     = 11;
   localparam int MODE_W     = 2;
   localparam int CMD_W      = 2;
   localparam int CODE_W     = 3;
   localparam int SLOT_W     = 10;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 11;
   localparam int MOD_CNT_W  = $clog2(KEY_W);

   // slot marks
   localparam logic [1:0] MARK_EMPTY    = 2'd0;
   localparam logic [1:0] MARK_OCCUPIED = 2'd1;
   localparam logic [1:0] MARK_DELETED  = 2'd2;

   // commands
   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd1;
   localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;

   // probe modes
   localparam logic [MODE_W-1:0] MODE_LINEAR    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_QUADRATIC = 2'd1;
   localparam logic [MODE_W-1:0] MODE_DOUBLE    = 2'd2;

   // result codes
   localparam logic [CODE_W-1:0] RC_INSERTED  = 3'd0;
   localparam logic [CODE_W-1:0] RC_FOUND     = 3'd1;
   localparam logic [CODE_W-1:0] RC_NOT_FOUND = 3'd2;
   localparam logic [CODE_W-1:0] RC_FULL      = 3'd3;
   localparam logic [CODE_W-1:0] RC_DELETED   = 3'd4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PROBE_MODE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TABLE_SIZE = 1'd1;

   typedef struct packed {
      logic [1:0]       mark;
      logic [KEY_W-1:0] key;
   } slot_type;

   typedef struct packed {
      logic              start;
      logic [KEY_W-1:0]  dividend;
      logic [SIZE_W-1:0] divisor;
   } mod_req_type;

   typedef struct packed {
      logic              done;
      logic [SIZE_W-1:0] rem;
   } mod_rsp_type;

endpackage

### rtl/oahs_mod_unit.sv
// bit-serial restoring remainder unit, one dividend bit per cycle
module oahs_mod_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  oahs_pkg::mod_req_type req,
   output oahs_pkg::mod_rsp_type rsp
);
   import oahs_pkg::*;

   logic                 busy_ff;
   logic                 done_ff;
   logic [MOD_CNT_W-1:0] cnt_ff;
   logic [SIZE_W-1:0]    rem_ff;
   logic [SIZE_W-1:0]    rem_in;
   logic [KEY_W-1:0]     div_ff;
   logic [SIZE_W-1:0]    d_ff;
   logic [SIZE_W:0]      trial;

   always_comb begin
      trial = {rem_ff, div_ff[KEY_W-1]};
      if (trial >= {1'b0, d_ff}) begin
         rem_in = SIZE_W'(trial - {1'b0, d_ff});
      end else begin
         rem_in = trial[SIZE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == MOD_CNT_W'(KEY_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         rem_ff <= '0;
         div_ff <= req.dividend;
         d_ff   <= req.divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         div_ff <= {div_ff[KEY_W-2:0], 1'b0};
      end
   end

   assign rsp.done = done_ff;
   assign rsp.rem  = rem_ff;

endmodule

### rtl/oahs_slot_ram.sv
// slot store: mark and key per slot, one write and one registered read port
module oahs_slot_ram (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [oahs_pkg::ADDR_W-1:0]    wr_addr,
   input  oahs_pkg::slot_type             wr_data,
   input  logic                           rd_en,
   input  logic [oahs_pkg::ADDR_W-1:0]    rd_addr,
   output oahs_pkg::slot_type             rd_data
);
   import oahs_pkg::*;

   slot_type mem [SLOT_DEPTH];
   slot_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/open_address_hash_set_top.sv
// open-address hash set top level: sequencer, probe stepping and result register
//
//  channel | ports                                   | dir | handshake
//  req     | req_command, req_key                    | in  | req_valid / req_stall
//  rsp     | rsp_result_code, rsp_slot_index, rsp_.. | out | rsp_valid / rsp_stall
//  csr     | csr_index, csr_wdata                    | in  | csr_wr_en, no wait
//
// an item is taken, then its home hash is formed (remainder shifts, then pick up), the step hash
// follows in double hashing, each probe is a slot read then a check, and finally the result word
// is loaded; a full table or unknown command goes from taking straight to loading the result
// after reset the slot store is swept to empty with req_stall high;
// csr writes are taken throughout
// req_stall is high from acceptance until the result is loaded; a held result only blocks the next load
module open_address_hash_set_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [oahs_pkg::CMD_W-1:0]        req_command,
   input  logic [oahs_pkg::KEY_W-1:0]        req_key,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [oahs_pkg::CODE_W-1:0]       rsp_result_code,
   output logic [oahs_pkg::SLOT_W-1:0]       rsp_slot_index,
   output logic [oahs_pkg::SIZE_W-1:0]       rsp_items_held,
   input  logic                              csr_wr_en,
   input  logic [oahs_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [oahs_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import oahs_pkg::*;

   localparam int ST_W = 3;
   localparam logic [ST_W-1:0] ST_CLEAR = 3'd0;
   localparam logic [ST_W-1:0] ST_IDLE  = 3'd1;
   localparam logic [ST_W-1:0] ST_HASH  = 3'd2;
   localparam logic [ST_W-1:0] ST_HASH2 = 3'd3;
   localparam logic [ST_W-1:0] ST_READ  = 3'd4;
   localparam logic [ST_W-1:0] ST_CHECK = 3'd5;
   localparam logic [ST_W-1:0] ST_DONE  = 3'd6;

   // registers
   logic [ST_W-1:0]   state_ff, state_in;
   logic [MODE_W-1:0] probe_mode_ff;
   logic [SIZE_W-1:0] table_size_ff;
   logic [SIZE_W-1:0] count_ff, count_in;
   logic [ADDR_W-1:0] clr_addr_ff;
   logic [CMD_W-1:0]  cmd_ff;
   logic [KEY_W-1:0]  key_ff;
   logic [SIZE_W-1:0] s_ff;
   logic [MODE_W-1:0] mode_ff;
   logic [SIZE_W-1:0] idx_ff, idx_in;
   logic [SIZE_W-1:0] delta_ff, delta_in;
   logic [SIZE_W-1:0] step_ff, step_in;
   logic [SIZE_W-1:0] probe_cnt_ff, probe_cnt_in;
   logic [CODE_W-1:0] code_ff, code_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic              rsp_valid_ff;
   logic [CODE_W-1:0] rsp_code_ff;
   logic [SLOT_W-1:0] rsp_slot_ff;
   logic [SIZE_W-1:0] rsp_items_ff;

   // combinational
   logic              req_take;
   logic [SIZE_W-1:0] s_use;
   logic [SIZE_W:0]   idx_sum, delta_sum;
   logic [SIZE_W-1:0] quad_init, quad_step;
   logic              key_hit;
   logic              rsp_load;
   mod_req_type       mreq;
   mod_rsp_type       mrsp;
   slot_type          ram_wdata, ram_rdata;
   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr;

   // size in use, clamped to [3, SLOT_DEPTH]
   always_comb begin
      if (table_size_ff < SIZE_W'(3)) begin
         s_use = SIZE_W'(3);
      end else if (32'(table_size_ff) > SLOT_DEPTH) begin
         s_use = SIZE_W'(SLOT_DEPTH);
      end else begin
         s_use = table_size_ff;
      end
   end

   // quadratic chain steps by 6i+4 between probes; both terms reduced mod size
   always_comb begin
      case (s_ff)
         SIZE_W'(3): begin quad_init = SIZE_W'(1); quad_step = SIZE_W'(0); end
         SIZE_W'(4): begin quad_init = SIZE_W'(0); quad_step = SIZE_W'(2); end
         SIZE_W'(5): begin quad_init = SIZE_W'(4); quad_step = SIZE_W'(1); end
         SIZE_W'(6): begin quad_init = SIZE_W'(4); quad_step = SIZE_W'(0); end
         default:    begin quad_init = SIZE_W'(4); quad_step = SIZE_W'(6); end
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_load  = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   // modular stepping: each operand is below size, so one subtract corrects
   assign idx_sum   = {1'b0, idx_ff} + {1'b0, delta_ff};
   assign delta_sum = {1'b0, delta_ff} + {1'b0, step_ff};

   assign key_hit = (ram_rdata.mark == MARK_OCCUPIED) && (ram_rdata.key == key_ff);

   // shared remainder unit: key mod size, then key mod (size-1) for double hashing
   always_comb begin
      mreq.start    = 1'b0;
      mreq.dividend = req_take ? req_key : key_ff;
      mreq.divisor  = req_take ? s_use : SIZE_W'(s_ff - 1'b1);
      if (req_take && ((req_command == CMD_SEARCH) || (req_command == CMD_DELETE) ||
                       ((req_command == CMD_INSERT) && (count_ff < s_use)))) begin
         mreq.start = 1'b1;
      end else if ((state_ff == ST_HASH) && mrsp.done && (mode_ff == MODE_DOUBLE)) begin
         mreq.start = 1'b1;
      end
   end

   oahs_mod_unit u_mod (
      .clock (clock),
      .reset (reset),
      .req   (mreq),
      .rsp   (mrsp)
   );

   oahs_slot_ram u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (state_ff == ST_READ),
      .rd_addr (idx_ff[ADDR_W-1:0]),
      .rd_data (ram_rdata)
   );

   // sequencer
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      delta_in     = delta_ff;
      step_in      = step_ff;
      probe_cnt_in = probe_cnt_ff;
      code_in      = code_ff;
      slot_in      = slot_ff;
      ram_we       = 1'b0;
      ram_waddr    = idx_ff[ADDR_W-1:0];
      ram_wdata.mark = MARK_OCCUPIED;
      ram_wdata.key  = key_ff;

      case (state_ff)
         ST_CLEAR: begin
            ram_we         = 1'b1;
            ram_waddr      = clr_addr_ff;
            ram_wdata.mark = MARK_EMPTY;
            ram_wdata.key  = '0;
            if (clr_addr_ff == ADDR_W'(SLOT_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_take) begin
               slot_in      = '0;
               probe_cnt_in = '0;
               if (mreq.start) begin
                  state_in = ST_HASH;
               end else begin
                  // unknown command or full table
                  code_in  = (req_command == CMD_INSERT) ? RC_FULL : RC_NOT_FOUND;
                  state_in = ST_DONE;
               end
            end
         end
         ST_HASH: begin
            if (mrsp.done) begin
               idx_in = mrsp.rem;
               case (mode_ff)
                  MODE_QUADRATIC: begin
                     delta_in = quad_init;
                     step_in  = quad_step;
                     state_in = ST_READ;
                  end
                  MODE_DOUBLE: begin
                     step_in  = '0;
                     state_in = ST_HASH2;
                  end
                  default: begin
                     delta_in = SIZE_W'(1);
                     step_in  = '0;
                     state_in = ST_READ;
                  end
               endcase
            end
         end
         ST_HASH2: begin
            if (mrsp.done) begin
               delta_in = SIZE_W'(s_ff - 1'b1 - mrsp.rem);
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (cmd_ff == CMD_INSERT && ram_rdata.mark != MARK_OCCUPIED) begin
               ram_we   = 1'b1;
               count_in = count_ff + 1'b1;
               code_in  = RC_INSERTED;
               slot_in  = idx_ff[SLOT_W-1:0];
               state_in = ST_DONE;
            end else if (cmd_ff != CMD_INSERT && ram_rdata.mark == MARK_EMPTY) begin
               code_in  = RC_NOT_FOUND;
               state_in = ST_DONE;
            end else if (cmd_ff != CMD_INSERT && key_hit) begin
               slot_in = idx_ff[SLOT_W-1:0];
               if (cmd_ff == CMD_DELETE) begin
                  ram_we         = 1'b1;
                  ram_wdata.mark = MARK_DELETED;
                  code_in        = RC_DELETED;
                  if (count_ff != '0) begin
                     count_in = count_ff - 1'b1;
                  end
               end else begin
                  code_in = RC_FOUND;
               end
               state_in = ST_DONE;
            end else if (probe_cnt_ff == SIZE_W'(s_ff - 1'b1)) begin
               // chain exhausted
               code_in  = (cmd_ff == CMD_INSERT) ? RC_FULL : RC_NOT_FOUND;
               state_in = ST_DONE;
            end else begin
               idx_in       = (idx_sum >= {1'b0, s_ff}) ? SIZE_W'(idx_sum - {1'b0, s_ff})
                                                         : idx_sum[SIZE_W-1:0];
               delta_in     = (delta_sum >= {1'b0, s_ff}) ? SIZE_W'(delta_sum - {1'b0, s_ff})
                                                           : delta_sum[SIZE_W-1:0];
               probe_cnt_in = probe_cnt_ff + 1'b1;
               state_in     = ST_READ;
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_addr_ff   <= '0;
         count_ff      <= '0;
         probe_mode_ff <= MODE_LINEAR;
         table_size_ff <= SIZE_W'(1024);
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (state_ff == ST_CLEAR) begin
            clr_addr_ff <= clr_addr_ff + 1'b1;
         end
         if (csr_wr_en) begin
            case (csr_index)
               CSR_PROBE_MODE: probe_mode_ff <= csr_wdata[MODE_W-1:0];
               CSR_TABLE_SIZE: table_size_ff <= csr_wdata[SIZE_W-1:0];
               default: ;
            endcase
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // working and payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         cmd_ff  <= req_command;
         key_ff  <= req_key;
         s_ff    <= s_use;
         mode_ff <= probe_mode_ff;
      end
      idx_ff       <= idx_in;
      delta_ff     <= delta_in;
      step_ff      <= step_in;
      probe_cnt_ff <= probe_cnt_in;
      code_ff      <= code_in;
      slot_ff      <= slot_in;
      if (rsp_load) begin
         rsp_code_ff  <= code_ff;
         rsp_slot_ff  <= slot_ff;
         rsp_items_ff <= count_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_code = rsp_code_ff;
   assign rsp_slot_index  = rsp_slot_ff;
   assign rsp_items_held  = rsp_items_ff;

`ifndef SYNTHESIS
   // a slot read always lands inside the size in use
   a_probe_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> (idx_ff < s_ff))
      else $error("probe index outside table");

   // remainder results only arrive while the sequencer waits on them
   a_mod_done_expected: assert property (@(posedge clock) disable iff (reset)
      mrsp.done |-> ((state_ff == ST_HASH) || (state_ff == ST_HASH2)))
      else $error("unexpected remainder result");

   // item count never exceeds the slot store
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= SLOT_DEPTH)
      else $error("item count overflow");

   // a loaded result is a legal code
   a_code_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> (rsp_valid_ff && (rsp_code_ff <= RC_DELETED)))
      else $error("illegal result code");
`endif

endmodule
